### src/text_console_cursor_scroll_core_assert.svh
// Assertion macros for the text console core checker.
// TCCS_ASSERT is gated off while reset is high; TCCS_ASSERT_NR is not.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH

`define TCCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TCCS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared constants, codes, control structs and address helpers for the
// text console core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccs_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);

   // field widths
   localparam int KIND_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int RCOL_W   = 7;
   localparam int RROW_W   = 5;
   localparam int OCOL_W   = 7;
   localparam int OROW_W   = 5;
   localparam int OFF_W    = 11;
   localparam int COLOUR_W = 8;
   localparam int CELL_W   = CHAR_W + COLOUR_W;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PUT       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BACKSPACE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ      = 2'd3;

   // character and attribute constants
   localparam logic [CHAR_W-1:0]   NEWLINE_BYTE = 8'h0A;
   localparam logic [CHAR_W-1:0]   SPACE_BYTE   = 8'h20;
   localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h07;

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

   // controller to datapath commands
   typedef struct packed {
      logic latch;       // capture the request beat
      logic exec;        // run the item against cursor and memory
      logic sweep;       // blank one cell of the sweep range
      logic sweep_init;  // sweep uses the reset attribute
      logic deliver;     // load the response register
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_sweep;  // item needs a row or screen blank
      logic sweep_last;  // sweep is on its final cell
   } ctrl_status_type;

   // logical row to physical row of the circular row store
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] lrow);
      logic [ROW_W:0] sum;
      sum = {1'b0, top} + {1'b0, lrow};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   // physical row and column to memory address
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(32'(prow) * COLUMNS + 32'(col));
   endfunction

endpackage

### src/tccs_req_if.sv
// ----------------------------------------------------------------------------
// tccs_req_if
// Request channel: one console item per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tccs_req_if;
   logic                          valid;
   logic                          ready;
   logic [tccs_pkg::KIND_W-1:0]   kind;
   logic [tccs_pkg::CHAR_W-1:0]   char_code;
   logic [tccs_pkg::RCOL_W-1:0]   read_column;
   logic [tccs_pkg::RROW_W-1:0]   read_row;

   modport source (output valid, kind, char_code, read_column, read_row,
                   input ready);
   modport sink (input valid, kind, char_code, read_column, read_row,
                 output ready);
endinterface

### src/tccs_rsp_if.sv
// ----------------------------------------------------------------------------
// tccs_rsp_if
// Response channel: cursor position and read data, one beat per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tccs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tccs_pkg::OCOL_W-1:0]     cursor_column;
   logic [tccs_pkg::OROW_W-1:0]     cursor_row;
   logic [tccs_pkg::OFF_W-1:0]      cursor_offset;
   logic [tccs_pkg::CHAR_W-1:0]     read_char;
   logic [tccs_pkg::COLOUR_W-1:0]   read_colour;
   logic                            scrolled;

   modport source (output valid, cursor_column, cursor_row, cursor_offset,
                   read_char, read_colour, scrolled, input ready);
   modport sink (input valid, cursor_column, cursor_row, cursor_offset,
                 read_char, read_colour, scrolled, output ready);
endinterface

### src/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer: reset clearing pass, item execution, blanking sweeps and
// response handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  tccs_pkg::ctrl_status_type status,
   output tccs_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_SWEEP  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep      = 1'b1;
            cmd.sweep_init = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_sweep ? ST_SWEEP : ST_FINISH;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hand off the result and take the next beat in the same cycle
            if (out_free) begin
               cmd.deliver = 1'b1;
               req_ready   = 1'b1;
               if (req_valid) begin
                  cmd.latch = 1'b1;
                  state_in  = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/tccs_dpath.sv
// ----------------------------------------------------------------------------
// tccs_dpath
// Cell memory with a circular row store, cursor, attribute register,
// blanking sweep counter and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  tccs_pkg::ctrl_cmd_type            cmd,
   output tccs_pkg::ctrl_status_type         status,
   input  logic                              csr_wr_en,
   input  logic [tccs_pkg::COLOUR_W-1:0]     csr_wr_data,
   input  logic [tccs_pkg::KIND_W-1:0]       req_kind,
   input  logic [tccs_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tccs_pkg::RCOL_W-1:0]       req_read_column,
   input  logic [tccs_pkg::RROW_W-1:0]       req_read_row,
   output logic [tccs_pkg::OCOL_W-1:0]       rsp_cursor_column,
   output logic [tccs_pkg::OROW_W-1:0]       rsp_cursor_row,
   output logic [tccs_pkg::OFF_W-1:0]        rsp_cursor_offset,
   output logic [tccs_pkg::CHAR_W-1:0]       rsp_read_char,
   output logic [tccs_pkg::COLOUR_W-1:0]     rsp_read_colour,
   output logic                              rsp_scrolled
);

   localparam int COL_W  = tccs_pkg::COL_W;
   localparam int ROW_W  = tccs_pkg::ROW_W;
   localparam int ADDR_W = tccs_pkg::ADDR_W;

   // cell memory
   logic [tccs_pkg::CELL_W-1:0] screen_mem [tccs_pkg::CELLS];
   logic [tccs_pkg::CELL_W-1:0] rd_data_ff;

   // registers
   logic [tccs_pkg::COLOUR_W-1:0] text_colour_ff;
   logic [tccs_pkg::KIND_W-1:0]   kind_ff;
   logic [tccs_pkg::CHAR_W-1:0]   char_ff;
   logic [tccs_pkg::RCOL_W-1:0]   rcol_ff;
   logic [tccs_pkg::RROW_W-1:0]   rrow_ff;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [ROW_W-1:0]              top_ff, top_in;
   logic [ADDR_W-1:0]             sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]             sweep_end_ff, sweep_end_in;
   logic                          scrolled_ff, scrolled_in;
   logic                          rd_hit_ff, rd_hit_in;

   logic [tccs_pkg::OCOL_W-1:0]   out_col_ff;
   logic [tccs_pkg::OROW_W-1:0]   out_row_ff;
   logic [tccs_pkg::OFF_W-1:0]    out_off_ff;
   logic [tccs_pkg::CHAR_W-1:0]   out_char_ff;
   logic [tccs_pkg::COLOUR_W-1:0] out_colour_ff;
   logic                          out_scrolled_ff;

   // memory ports
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [tccs_pkg::CELL_W-1:0]   wr_data;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;

   // cursor arithmetic
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;
   logic [COL_W-1:0] col_dec;
   logic [ROW_W-1:0] cur_phys;
   logic [ROW_W-1:0] rd_phys;
   logic [ROW_W-1:0] top_inc;
   logic             is_put, is_nl, col_wrap, row_over, adv_row, overflow;
   logic             rd_in_range;

   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign col_dec  = col_ff - 1'b1;
   assign col_wrap = col_inc >= (COL_W+1)'(tccs_pkg::COLUMNS);
   assign row_over = row_inc >= (ROW_W+1)'(tccs_pkg::ROWS);
   assign is_put   = kind_ff == tccs_pkg::KIND_PUT;
   assign is_nl    = char_ff == tccs_pkg::NEWLINE_BYTE;
   assign adv_row  = is_nl || col_wrap;
   assign overflow = is_put && adv_row && row_over;
   assign top_inc  = (top_ff == tccs_pkg::ROW_LAST) ? '0 : top_ff + 1'b1;
   assign cur_phys = tccs_pkg::phys_row(top_ff, row_ff);
   assign rd_phys  = tccs_pkg::phys_row(top_ff, ROW_W'(rrow_ff));

   assign rd_in_range = (32'(rcol_ff) < tccs_pkg::COLUMNS) &&
                        (32'(rrow_ff) < tccs_pkg::ROWS);

   assign status.need_sweep = (kind_ff == tccs_pkg::KIND_CLEAR) || overflow;
   assign status.sweep_last = sweep_addr_ff == sweep_end_ff;

   // item execution and sweep writes
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      top_in        = top_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_end_in  = sweep_end_ff;
      scrolled_in   = scrolled_ff;
      rd_hit_in     = rd_hit_ff;
      wr_en         = 1'b0;
      wr_addr       = sweep_addr_ff;
      wr_data       = {text_colour_ff, tccs_pkg::SPACE_BYTE};
      rd_en         = 1'b0;
      rd_addr       = tccs_pkg::cell_addr(rd_phys, COL_W'(rcol_ff));

      if (cmd.exec) begin
         scrolled_in = 1'b0;
         rd_hit_in   = 1'b0;
         case (kind_ff)
            tccs_pkg::KIND_PUT: begin
               if (!is_nl) begin
                  wr_en   = 1'b1;
                  wr_addr = tccs_pkg::cell_addr(cur_phys, col_ff);
                  wr_data = {text_colour_ff, char_ff};
               end
               col_in = adv_row ? '0 : col_inc[COL_W-1:0];
               if (adv_row) begin
                  if (row_over) begin
                     // scroll: old top row becomes the blank bottom row
                     row_in        = tccs_pkg::ROW_LAST;
                     top_in        = top_inc;
                     sweep_addr_in = tccs_pkg::cell_addr(top_ff, '0);
                     sweep_end_in  = tccs_pkg::cell_addr(top_ff, tccs_pkg::COL_LAST);
                     scrolled_in   = 1'b1;
                  end else begin
                     row_in = row_inc[ROW_W-1:0];
                  end
               end
            end
            tccs_pkg::KIND_BACKSPACE: begin
               if (col_ff != '0) begin
                  col_in  = col_dec;
                  wr_en   = 1'b1;
                  wr_addr = tccs_pkg::cell_addr(cur_phys, col_dec);
               end
            end
            tccs_pkg::KIND_CLEAR: begin
               col_in        = '0;
               row_in        = '0;
               top_in        = '0;
               sweep_addr_in = '0;
               sweep_end_in  = ADDR_W'(tccs_pkg::CELLS - 1);
            end
            tccs_pkg::KIND_READ: begin
               rd_en     = rd_in_range;
               rd_hit_in = rd_in_range;
            end
            default: begin
               rd_hit_in = 1'b0;
            end
         endcase
      end

      if (cmd.sweep) begin
         wr_en         = 1'b1;
         wr_addr       = sweep_addr_ff;
         wr_data       = {cmd.sweep_init ? tccs_pkg::RESET_COLOUR : text_colour_ff,
                          tccs_pkg::SPACE_BYTE};
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end
   end

   // cell memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   // control state; the sweep range starts as the whole screen for the
   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         text_colour_ff <= tccs_pkg::RESET_COLOUR;
         col_ff         <= '0;
         row_ff         <= '0;
         top_ff         <= '0;
         sweep_addr_ff  <= '0;
         sweep_end_ff   <= ADDR_W'(tccs_pkg::CELLS - 1);
      end else begin
         if (csr_wr_en) begin
            text_colour_ff <= csr_wr_data;
         end
         col_ff        <= col_in;
         row_ff        <= row_in;
         top_ff        <= top_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_end_ff  <= sweep_end_in;
      end
   end

   // request capture and per-item flags
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         char_ff <= req_char_code;
         rcol_ff <= req_read_column;
         rrow_ff <= req_read_row;
      end
      scrolled_ff <= scrolled_in;
      rd_hit_ff   <= rd_hit_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         out_col_ff      <= tccs_pkg::OCOL_W'(col_ff);
         out_row_ff      <= tccs_pkg::OROW_W'(row_ff);
         out_off_ff      <= tccs_pkg::OFF_W'(32'(row_ff) * tccs_pkg::COLUMNS + 32'(col_ff));
         out_char_ff     <= rd_hit_ff ? rd_data_ff[tccs_pkg::CHAR_W-1:0] : '0;
         out_colour_ff   <= rd_hit_ff ? rd_data_ff[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W] : '0;
         out_scrolled_ff <= scrolled_ff;
      end
   end

   assign rsp_cursor_column = out_col_ff;
   assign rsp_cursor_row    = out_row_ff;
   assign rsp_cursor_offset = out_off_ff;
   assign rsp_read_char     = out_char_ff;
   assign rsp_read_colour   = out_colour_ff;
   assign rsp_scrolled      = out_scrolled_ff;

endmodule

### src/text_console_cursor_scroll_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Flow: idle latches a request beat, execute runs the item, sweep blanks
// cells for a scrolling put or a clear, and finish loads the response
// register once the response channel is free, taking the next beat too.
// Sweeps blank one cell a cycle through the single write port of the cell
// memory. Reset: cursor homes, attribute 0x07, then a clearing pass over all
// CELLS cells with request ready low; csr writes are taken during the pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_scroll_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tccs_pkg::COLOUR_W-1:0]   csr_wr_data,
   tccs_req_if.sink                        req_chan,
   tccs_rsp_if.source                      rsp_chan
);

   tccs_pkg::ctrl_cmd_type    cmd;
   tccs_pkg::ctrl_status_type status;

   // sequencer
   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   tccs_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_kind          (req_chan.kind),
      .req_char_code     (req_chan.char_code),
      .req_read_column   (req_chan.read_column),
      .req_read_row      (req_chan.read_row),
      .rsp_cursor_column (rsp_chan.cursor_column),
      .rsp_cursor_row    (rsp_chan.cursor_row),
      .rsp_cursor_offset (rsp_chan.cursor_offset),
      .rsp_read_char     (rsp_chan.read_char),
      .rsp_read_colour   (rsp_chan.read_colour),
      .rsp_scrolled      (rsp_chan.scrolled)
   );

endmodule

### src/tccs_checker.sv
// ----------------------------------------------------------------------------
// tccs_checker
// Port-level checks for the text console core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_cursor_scroll_core_assert.svh"

module tccs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tccs_pkg::OCOL_W-1:0]     rsp_cursor_column,
   input logic [tccs_pkg::OROW_W-1:0]     rsp_cursor_row,
   input logic [tccs_pkg::OFF_W-1:0]      rsp_cursor_offset,
   input logic [tccs_pkg::CHAR_W-1:0]     rsp_read_char,
   input logic [tccs_pkg::COLOUR_W-1:0]   rsp_read_colour,
   input logic                            rsp_scrolled
);

   // a stalled response beat holds
   `TCCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_offset) && $stable(rsp_read_char) && $stable(rsp_read_colour), "response beat changed while stalled")

   // an accepted beat is executed before the next is taken
   `TCCS_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "request taken during execution")

   // a scroll leaves the cursor at the start of the last row
   `TCCS_ASSERT(a_scroll_cursor, clock, reset, rsp_valid && rsp_scrolled |-> rsp_cursor_column == '0 && rsp_cursor_row == tccs_pkg::OROW_W'(tccs_pkg::ROWS - 1), "scroll with cursor off the last row start")

   // clearing pass holds off requests after reset
   `TCCS_ASSERT_NR(a_init_busy, clock, reset |=> !req_ready, "request ready during clearing pass")

endmodule

bind text_console_cursor_scroll_core tccs_checker u_tccs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_cursor_column (rsp_chan.cursor_column),
   .rsp_cursor_row    (rsp_chan.cursor_row),
   .rsp_cursor_offset (rsp_chan.cursor_offset),
   .rsp_read_char     (rsp_chan.read_char),
   .rsp_read_colour   (rsp_chan.read_colour),
   .rsp_scrolled      (rsp_chan.scrolled)
);
